@@ src/khc_pkg.sv @@
// khc_pkg: shared types and constants of the k-mer histogram counter
// holds request, result, queue entry and configuration structs, command and status codes
// no dependencies
`default_nettype none

package khc_pkg;

  // fixed limits of the symbol window
  localparam int MAX_SYMBOLS = 8;
  localparam int MAX_KMER    = 16;
  localparam int MAX_USABLE  = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;
  localparam int SYM_W       = (MAX_USABLE > 2) ? $clog2(MAX_USABLE) : 1;

  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_SMALL   = 2'd3;

  localparam logic [1:0] CFG_ALPHABET_SIZE  = 2'd0;
  localparam logic [1:0] CFG_ALPHABET_CHARS = 2'd1;
  localparam logic [1:0] CFG_WINDOW_LEN     = 2'd2;

  localparam logic [3:0]  RST_ALPHABET_SIZE  = 4'd4;
  localparam logic [63:0] RST_ALPHABET_CHARS = 64'd1413695297;
  localparam logic [4:0]  RST_WINDOW_LEN     = 5'd8;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol_char;
    logic        sequence_start;
    logic [15:0] entry_address;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        kmer_counted;
    logic [15:0] kmer_index;
    logic [1:0]  status;
  } rsp_t;

  // classified request as it waits for the execution side
  typedef struct packed {
    logic [1:0]       command;
    logic             found;
    logic [SYM_W-1:0] pos;
    logic             sequence_start;
    logic [15:0]      entry_address;
    logic [31:0]      entry_value;
  } entry_t;

  // settled configuration as seen by the front and back
  typedef struct packed {
    logic [63:0] alphabet_chars;
    logic [3:0]  n;
    logic [4:0]  k;
    logic        undersized;
    logic        busy;
    logic        done;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/khc_config.sv @@
// khc_config: configuration registers and table span computation
// computes the symbol count to the power of the window length, then its multiples
// depends on khc_pkg
`default_nettype none

module khc_config import khc_pkg::*; #(
  parameter int TABLE_DEPTH = 65536,
  localparam int SPAN_W = $clog2(TABLE_DEPTH + 1) + 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  output cfg_t                   cfg,
  output logic [SPAN_W-1:0]      span_mult [8]
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_MUL  = 2'd1;
  localparam logic [1:0] C_FIN  = 2'd2;

  logic [3:0]        alphabet_size;
  logic [63:0]       alphabet_chars;
  logic [4:0]        window_len;
  logic [1:0]        state;
  logic [SPAN_W-1:0] span;
  logic [4:0]        step;
  logic              undersized;
  logic              done;

  logic [3:0]        n_use;
  logic [4:0]        k_use;
  logic [SPAN_W-1:0] prod;
  logic [SPAN_W-1:0] span_fix;

  assign n_use    = (alphabet_size > 4'(MAX_USABLE)) ? 4'(MAX_USABLE) : alphabet_size;
  assign k_use    = (window_len == 5'd0) ? 5'd1 : window_len;
  assign prod     = span * SPAN_W'(n_use);
  // an empty alphabet gives a zero span, which acts as one
  assign span_fix = (span == '0) ? SPAN_W'(1) : span;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size  <= RST_ALPHABET_SIZE;
      alphabet_chars <= RST_ALPHABET_CHARS;
      window_len     <= RST_WINDOW_LEN;
      state          <= C_MUL;
      span           <= SPAN_W'(1);
      step           <= 5'd0;
      undersized     <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_MUL: begin
          if (k_use > 5'(MAX_KMER)) begin
            undersized <= 1'b1;
            state      <= C_FIN;
          end else if (step == k_use) begin
            state <= C_FIN;
          end else if (prod > SPAN_W'(TABLE_DEPTH)) begin
            undersized <= 1'b1;
            state      <= C_FIN;
          end else begin
            span <= prod;
            step <= 5'(step + 5'd1);
          end
        end
        C_FIN: begin
          span  <= span_fix;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: begin
        end
      endcase
      if (cfg_write) begin
        case (cfg_index)
          CFG_ALPHABET_SIZE:  alphabet_size  <= cfg_data[3:0];
          CFG_ALPHABET_CHARS: alphabet_chars <= cfg_data;
          CFG_WINDOW_LEN:     window_len     <= cfg_data[4:0];
          default: begin
          end
        endcase
        state      <= C_MUL;
        span       <= SPAN_W'(1);
        step       <= 5'd0;
        undersized <= 1'b0;
        done       <= 1'b0;
      end
    end
  end

  // multiples of the span let the back reduce with one subtract
  always_ff @(posedge clk) begin
    if (state == C_FIN) begin
      for (int j = 0; j < 8; j++) begin
        span_mult[j] <= SPAN_W'(span_fix * SPAN_W'(j));
      end
    end
  end

  assign cfg.alphabet_chars = alphabet_chars;
  assign cfg.n              = n_use;
  assign cfg.k              = k_use;
  assign cfg.undersized     = undersized;
  assign cfg.busy           = (state != C_IDLE);
  assign cfg.done           = done;

endmodule

`default_nettype wire

@@ src/khc_front.sv @@
// khc_front: classifies an incoming request
// folds case and finds the highest alphabet position that matches
// depends on khc_pkg
`default_nettype none

module khc_front import khc_pkg::*; (
  input  wire req_t    request,
  input  wire cfg_t    cfg,
  output entry_t       entry
);

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 8'(c + 8'h20);
    end
    return r;
  endfunction

  logic [7:0]       want;
  logic             found;
  logic [SYM_W-1:0] pos;

  assign want = fold_case(request.symbol_char);

  // later positions override earlier ones
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < MAX_USABLE; i++) begin
      if (4'(i) < cfg.n && fold_case(cfg.alphabet_chars[8*i +: 8]) == want) begin
        found = 1'b1;
        pos   = SYM_W'(i);
      end
    end
  end

  assign entry.command        = request.command;
  assign entry.found          = found;
  assign entry.pos            = pos;
  assign entry.sequence_start = request.sequence_start;
  assign entry.entry_address  = request.entry_address;
  assign entry.entry_value    = request.entry_value;

endmodule

`default_nettype wire

@@ src/khc_queue.sv @@
// khc_queue: two-entry queue of classified requests
// parts the accepting front from the executing back
// depends on khc_pkg
`default_nettype none

module khc_queue import khc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t din,
  input  wire logic   pop,
  output entry_t      head,
  output logic        full,
  output logic        empty
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= 2'(count + 2'd1);
        2'b01:   count <= 2'(count - 2'd1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign head  = slots[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

`default_nettype wire

@@ src/khc_back.sv @@
// khc_back: executes queued requests against the count table
// holds the rolling index, run length, table memory and its clearing pass
// depends on khc_pkg
`default_nettype none

module khc_back import khc_pkg::*; #(
  parameter int TABLE_DEPTH = 65536,
  parameter int COUNT_WIDTH = 32,
  localparam int SPAN_W = $clog2(TABLE_DEPTH + 1) + 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic [SPAN_W-1:0] span_mult [8],
  input  wire entry_t            head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   clearing,
  output logic                   done,
  output rsp_t                   result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int RC_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_RED   = 3'd2;
  localparam logic [2:0] B_MOD   = 3'd3;
  localparam logic [2:0] B_INC   = 3'd4;
  localparam logic [2:0] B_RDOUT = 3'd5;

  logic [2:0]             state;
  logic [IDX_W-1:0]       clr_addr;
  logic [IDX_W-1:0]       ri;
  logic [4:0]             vr;
  logic                   red_pend;
  logic [IDX_W-1:0]       r;
  logic [IDX_W-1:0]       rsh;
  logic [RC_W-1:0]        rcnt;
  logic [SPAN_W-1:0]      v;
  logic                   counted;

  logic [COUNT_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]       mem_raddr;

  logic                   red_req;
  logic [IDX_W-1:0]       base;
  logic [4:0]             vr_base;
  logic [4:0]             vr_inc;
  logic [SPAN_W-1:0]      v_calc;
  logic                   in_range;
  logic [IDX_W-1:0]       e_idx;
  logic [COUNT_WIDTH-1:0] wval;
  logic [SPAN_W-1:0]      sub;
  logic [IDX_W-1:0]       ri_new;
  logic [IDX_W:0]         t_shift;
  logic [IDX_W:0]         t_red;
  logic [COUNT_WIDTH-1:0] c_inc;

  assign red_req  = red_pend || cfg.done;
  assign pop      = (state == B_IDLE) && !red_req && !cfg.busy && !empty;
  assign clearing = (state == B_CLEAR);

  assign base     = head.sequence_start ? '0 : ri;
  assign vr_base  = head.sequence_start ? 5'd0 : vr;
  assign vr_inc   = (vr_base < cfg.k) ? 5'(vr_base + 5'd1) : vr_base;
  assign v_calc   = SPAN_W'(SPAN_W'(base) * SPAN_W'(cfg.n) + SPAN_W'(head.pos));
  assign in_range = 32'(head.entry_address) < 32'(TABLE_DEPTH);
  assign e_idx    = IDX_W'(head.entry_address);
  assign wval     = COUNT_WIDTH'(head.entry_value);

  // quotient is below eight, so pick the largest multiple not above v
  always_comb begin
    sub = '0;
    for (int j = 1; j < 8; j++) begin
      if (v >= span_mult[j]) sub = span_mult[j];
    end
  end
  assign ri_new = IDX_W'(v - sub);

  // one remainder bit per cycle after a configuration change, unless the configuration moves again
  assign t_shift = {r, rsh[IDX_W-1]};
  assign t_red   = (SPAN_W'(t_shift) >= span_mult[1]) ?
                   (IDX_W+1)'(t_shift - (IDX_W+1)'(span_mult[1])) : t_shift;

  assign c_inc = (&rdata) ? rdata : COUNT_WIDTH'(rdata + 1'b1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ri;
    mem_wdata = c_inc;
    mem_raddr = ri;
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      B_IDLE: begin
        mem_raddr = e_idx;
        if (pop && head.command == CMD_WRITE && in_range) begin
          mem_we    = 1'b1;
          mem_waddr = e_idx;
          mem_wdata = wval;
        end
      end
      B_MOD: begin
        mem_raddr = ri_new;
      end
      B_INC: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      ri       <= '0;
      vr       <= 5'd0;
      red_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      red_pend <= red_pend || cfg.done;
      unique case (state)
        B_CLEAR: begin
          clr_addr <= IDX_W'(clr_addr + 1'b1);
          if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (red_req) begin
            red_pend <= 1'b0;
            if (!cfg.undersized) begin
              state <= B_RED;
              r     <= '0;
              rsh   <= ri;
              rcnt  <= '0;
            end
          end else if (pop) begin
            unique case (head.command)
              CMD_FEED: begin
                if (cfg.undersized) begin
                  done   <= 1'b1;
                  result <= '{read_data: '0, kmer_counted: 1'b0, kmer_index: '0,
                              status: ST_SMALL};
                end else if (!head.found) begin
                  ri     <= '0;
                  vr     <= 5'd0;
                  done   <= 1'b1;
                  result <= '{read_data: '0, kmer_counted: 1'b0, kmer_index: '0,
                              status: ST_UNKNOWN};
                end else begin
                  vr      <= vr_inc;
                  v       <= v_calc;
                  counted <= (vr_inc >= cfg.k);
                  state   <= B_MOD;
                end
              end
              CMD_READ: begin
                if (!in_range) begin
                  done   <= 1'b1;
                  result <= '{read_data: '0, kmer_counted: 1'b0, kmer_index: '0,
                              status: ST_RANGE};
                end else begin
                  state <= B_RDOUT;
                end
              end
              CMD_WRITE: begin
                done <= 1'b1;
                if (!in_range) begin
                  result <= '{read_data: '0, kmer_counted: 1'b0, kmer_index: '0,
                              status: ST_RANGE};
                end else begin
                  result <= '{read_data: 32'(wval), kmer_counted: 1'b0,
                              kmer_index: '0, status: ST_OK};
                end
              end
              CMD_NONE: begin
                done   <= 1'b1;
                result <= '{read_data: '0, kmer_counted: 1'b0, kmer_index: '0,
                            status: ST_OK};
              end
              default: begin
              end
            endcase
          end
        end
        B_RED: begin
          if (cfg.busy) begin
            // configuration moved again; redo once it settles
            state <= B_IDLE;
          end else if (rcnt == RC_W'(IDX_W - 1)) begin
            ri    <= t_red[IDX_W-1:0];
            state <= B_IDLE;
          end else begin
            r    <= t_red[IDX_W-1:0];
            rsh  <= {rsh[IDX_W-2:0], 1'b0};
            rcnt <= RC_W'(rcnt + 1'b1);
          end
        end
        B_MOD: begin
          ri <= ri_new;
          if (counted) begin
            state <= B_INC;
          end else begin
            done   <= 1'b1;
            result <= '{read_data: '0, kmer_counted: 1'b0, kmer_index: '0,
                        status: ST_OK};
            state  <= B_IDLE;
          end
        end
        B_INC: begin
          done   <= 1'b1;
          result <= '{read_data: 32'(c_inc), kmer_counted: 1'b1,
                      kmer_index: 16'(ri), status: ST_OK};
          state  <= B_IDLE;
        end
        B_RDOUT: begin
          done   <= 1'b1;
          result <= '{read_data: 32'(rdata), kmer_counted: 1'b0, kmer_index: '0,
                      status: ST_OK};
          state  <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/kmer_histogram_counter.sv @@
// kmer_histogram_counter: top level of the k-mer histogram counter
// ties khc_config, khc_front, khc_queue and khc_back together; depends on khc_pkg
//
// A request is taken at a clock edge where start is high and busy is low; each
// request gives exactly one result, shown on result for one cycle with done high,
// and the receiver cannot hold it off. Requests are classified on entry and wait
// in a two-entry queue, so start may be given while earlier work goes on. The
// execution side takes one request at a time: a feed that counts multiplies into
// the rolling index, then does the modulo select with table read, then the count
// update and write-back; a feed of a known symbol that does not count ends after
// the modulo select, a table read passes through a readout state, and everything
// else is answered from the idle state. After reset busy stays high while the
// table is cleared. After a configuration write the table span is recomputed and
// then the rolling index reduced bit by bit; requests taken meanwhile wait in the
// queue.
`default_nettype none

module kmer_histogram_counter import khc_pkg::*; #(
  parameter int TABLE_DEPTH = 65536,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        request,
  output logic             done,
  output rsp_t             result,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int SPAN_W = $clog2(TABLE_DEPTH + 1) + 3;

  cfg_t              cfg;
  logic [SPAN_W-1:0] span_mult [8];
  entry_t            entry;
  entry_t            head;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic              clearing;
  logic              push;

  assign busy = q_full || clearing;
  assign push = start && !busy;

  khc_config #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .span_mult (span_mult)
  );

  khc_front u_front (
    .request (request),
    .cfg     (cfg),
    .entry   (entry)
  );

  khc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (q_pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  khc_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .span_mult (span_mult),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .clearing  (clearing),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire
